// ----- rtl/linear_probe_hash_table_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the linear probing hash table unit
// Clocked assertion shorthands; defining ASSERT_OFF turns them into nothing.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge of clk while rst_n is high.
`define LPHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define LPHT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPHT_ASSERT(lbl, prop, msg)
`define LPHT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/lpht_pkg.sv -----
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and codes of the linear probing hash table unit.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // Default number of slots in the table.
  localparam int TABLE_SIZE_DEF = 16;

  // Field widths.
  localparam int KEY_W    = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;

  // The home slot is worked out MOD_BITS key bits per cycle.
  localparam int MOD_BITS  = 8;
  localparam int MOD_STEPS = KEY_W / MOD_BITS;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // Slot state codes held next to each key.
  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_USED  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_FETCH,
    S_PROBE
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;    // write an empty slot at the sweep address
    logic load;     // capture a new word and start the home slot divide
    logic hash;     // one divide step
    logic advance;  // step the read address to the next slot
    logic probe;    // judge the slot read in the previous cycle
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic hash_done;
    logic stop;
  } dp_stat_t;

endpackage

// ----- rtl/lpht_dp.sv -----
// ----------------------------------------------------------------------------
// lpht_dp
// Datapath: home slot divider, slot memory, probe judge and result register.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_unit_macros.svh"

module lpht_dp #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lpht_pkg::dp_cmd_t              cmd,
  output lpht_pkg::dp_stat_t             stat,
  input  logic [lpht_pkg::CMD_W-1:0]     in_command,
  input  logic [lpht_pkg::KEY_W-1:0]     in_key,
  output logic                           out_valid,
  output logic [lpht_pkg::STATUS_W-1:0]  out_status,
  output logic [lpht_pkg::SLOT_W-1:0]    out_slot_index
);
  import lpht_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_SIZE);
  localparam int WORD_W = KEY_W + 2;
  localparam logic [ADDR_W-1:0] LastSlot = ADDR_W'(TABLE_SIZE - 1);
  localparam logic [ADDR_W:0]   Modulus  = (ADDR_W + 1)'(TABLE_SIZE);

  // Captured word.
  logic [KEY_W-1:0]     key_r;
  logic [CMD_W-1:0]     cmd_r;

  // Divider state.
  logic [KEY_W-1:0]     key_sh_r, key_sh_nxt;
  logic [ADDR_W-1:0]    rem_r, rem_nxt;
  logic [MOD_CNT_W-1:0] mod_cnt_r;

  // Probe addressing.
  logic [ADDR_W-1:0]    issue_addr_r, issue_addr_nxt;
  logic [ADDR_W-1:0]    data_addr_r;
  logic [ADDR_W-1:0]    probe_cnt_r;

  // Slot memory: slot state in the top two bits, key below.
  logic [WORD_W-1:0]    mem [TABLE_SIZE];
  logic [WORD_W-1:0]    mem_q_r;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [WORD_W-1:0]    mem_wdata;

  // Probe judge.
  logic [1:0]           slot_state;
  logic [KEY_W-1:0]     slot_key;
  logic                 last_probe;
  logic                 hit_stop;
  logic                 hit_ok;
  logic                 hit_write;
  logic [WORD_W-1:0]    hit_wdata;
  logic [STATUS_W-1:0]  res_status;
  logic [31:0]          res_slot_wide;

  // Output registers.
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [SLOT_W-1:0]    out_slot_r;

  // Restoring remainder, MOD_BITS key bits per cycle, divisor is constant.
  always_comb begin
    logic [ADDR_W:0] r;
    r = {1'b0, rem_r};
    for (int i = 0; i < MOD_BITS; i++) begin
      r = {r[ADDR_W-1:0], key_sh_r[KEY_W-1-i]};
      if (r >= Modulus) begin
        r = r - Modulus;
      end
    end
    rem_nxt    = r[ADDR_W-1:0];
    key_sh_nxt = key_sh_r << MOD_BITS;
  end

  // Divider and captured word registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_cnt_r <= '0;
    end else if (cmd.load) begin
      mod_cnt_r <= '0;
    end else if (cmd.hash) begin
      mod_cnt_r <= mod_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r    <= in_key;
      cmd_r    <= in_command;
      key_sh_r <= in_key;
      rem_r    <= '0;
    end else if (cmd.hash) begin
      key_sh_r <= key_sh_nxt;
      rem_r    <= rem_nxt;
    end
  end

  assign stat.hash_done  = cmd.hash && (mod_cnt_r == MOD_CNT_W'(MOD_STEPS - 1));
  assign stat.clear_done = cmd.clear && (issue_addr_r == LastSlot);

  // Read address: loaded with the home slot on the last divide step,
  // then stepped with wrap once per cycle while clearing, fetching or probing.
  always_comb begin
    issue_addr_nxt = issue_addr_r;
    if (stat.hash_done) begin
      issue_addr_nxt = rem_nxt;
    end else if (cmd.advance) begin
      issue_addr_nxt = (issue_addr_r == LastSlot) ? '0 : issue_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_addr_r <= '0;
      probe_cnt_r  <= '0;
    end else begin
      issue_addr_r <= issue_addr_nxt;
      if (cmd.hash) begin
        probe_cnt_r <= '0;
      end else if (cmd.probe) begin
        probe_cnt_r <= probe_cnt_r + 1'b1;
      end
    end
  end

  // Slot memory with one write port and one registered read port.
  assign mem_we    = cmd.clear || (cmd.probe && hit_write);
  assign mem_waddr = cmd.clear ? issue_addr_r : data_addr_r;
  assign mem_wdata = cmd.clear ? {SLOT_EMPTY, {KEY_W{1'b0}}} : hit_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r     <= mem[issue_addr_r];
    data_addr_r <= issue_addr_r;
  end

  // Judge the slot that was just read.
  assign slot_state = mem_q_r[WORD_W-1 -: 2];
  assign slot_key   = mem_q_r[KEY_W-1:0];
  assign last_probe = (probe_cnt_r == LastSlot);

  always_comb begin
    logic used;
    logic match;
    used      = (slot_state == SLOT_USED);
    match     = used && (slot_key == key_r);
    hit_stop  = 1'b1;
    hit_ok    = 1'b0;
    hit_write = 1'b0;
    hit_wdata = {SLOT_USED, key_r};
    unique case (cmd_r)
      CMD_INSERT: begin
        hit_stop  = !used || last_probe;
        hit_ok    = !used;
        hit_write = !used;
      end
      CMD_SEARCH: begin
        hit_stop = (slot_state == SLOT_EMPTY) || match || last_probe;
        hit_ok   = match;
      end
      CMD_DELETE: begin
        hit_stop  = (slot_state == SLOT_EMPTY) || match || last_probe;
        hit_ok    = match;
        hit_write = match;
        hit_wdata = {SLOT_TOMB, slot_key};
      end
      default: begin
        hit_stop = 1'b1;
        hit_ok   = 1'b0;
      end
    endcase
  end

  assign stat.stop = cmd.probe && hit_stop;

  // Result word.
  always_comb begin
    if (hit_ok) begin
      res_status = ST_OK;
    end else if (cmd_r == CMD_INSERT) begin
      res_status = ST_FULL;
    end else begin
      res_status = ST_MISSING;
    end
    res_slot_wide = hit_ok ? 32'(data_addr_r) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stat.stop;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.stop) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot_wide[SLOT_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_r;

  // A result is a one-cycle strobe.
  `LPHT_ASSERT(a_out_single, out_valid_r |=> !out_valid_r, "result strobe longer than one cycle")
  // A failed command reports slot zero.
  `LPHT_ASSERT(a_fail_slot_zero, (out_valid_r && out_status_r != ST_OK) |-> (out_slot_r == '0),
    "nonzero slot with failing status")
  // A probe never runs past one full circuit.
  `LPHT_ASSERT(a_circuit_bound, (cmd.probe && last_probe) |-> stat.stop,
    "probe ran past a full circuit")

endmodule

// ----- rtl/lpht_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpht_ctrl
// Controller: sequences clear sweep, home slot divide, read priming and probe.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_unit_macros.svh"

module lpht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output lpht_pkg::dp_cmd_t   cmd,
  input  lpht_pkg::dp_stat_t  stat
);
  import lpht_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (stat.clear_done) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_HASH;
      S_HASH:  if (stat.hash_done) state_nxt = S_FETCH;
      S_FETCH: state_nxt = S_PROBE;
      S_PROBE: if (stat.stop) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear   = 1'b1;
        cmd.advance = 1'b1;
      end
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_HASH: begin
        cmd.hash = 1'b1;
      end
      S_FETCH: begin
        cmd.advance = 1'b1;
      end
      S_PROBE: begin
        cmd.probe   = 1'b1;
        cmd.advance = 1'b1;
      end
      default: begin
        cmd  = '0;
        busy = 1'b1;
      end
    endcase
  end

  // An accepted word goes straight to the divider.
  `LPHT_ASSERT(a_accept_hash, (start && !busy) |=> (state_r == S_HASH),
    "accepted word did not start the divide")
  // The datapath only reports a stop while probing.
  `LPHT_ASSERT(a_stop_in_probe, stat.stop |-> (state_r == S_PROBE), "stop outside probe")
  // The sweep never overlaps a load, a divide step or a probe.
  `LPHT_ASSERT_ALWAYS(a_no_overlap, !(cmd.clear && (cmd.hash || cmd.load || cmd.probe)),
    "clear overlaps item work")

endmodule

// ----- rtl/linear_probe_hash_table_unit.sv -----
// ----------------------------------------------------------------------------
// Linear probing hash table unit
// Open-addressing table with tombstones: insert, search and delete by key.
// ----------------------------------------------------------------------------
// Operation: after start is taken, the key is divided for its home slot, the
// slot memory's read is primed, and then k slots (1 to TABLE_SIZE) are probed,
// one per cycle from the slot memory's read port; the result is registered.
// A new word is taken only while idle, once the last word's probe has stopped.
// Reset: a sweep marks every slot empty, busy held high.
// The receiver cannot stall: each result is a single-cycle out_valid strobe.
module linear_probe_hash_table_unit #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [lpht_pkg::CMD_W-1:0]     in_command,
  input  logic [lpht_pkg::KEY_W-1:0]     in_key,
  output logic                           out_valid,
  output logic [lpht_pkg::STATUS_W-1:0]  out_status,
  output logic [lpht_pkg::SLOT_W-1:0]    out_slot_index
);
  import lpht_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  lpht_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Table storage and probe logic.
  lpht_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_command     (in_command),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_slot_index (out_slot_index)
  );

endmodule
